### design/tws_pkg.sv
// Shared constants and types of the toast weight-loss sequencer.
package tws_pkg;

  // Run phases as they appear on the result stream.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WAIT  = 3'd1;
  localparam logic [2:0] PH_CAL   = 3'd2;
  localparam logic [2:0] PH_TOAST = 3'd3;
  localparam logic [2:0] PH_READY = 3'd4;

  // Finish causes, highest priority first.
  localparam logic [1:0] FIN_NONE   = 2'd0;
  localparam logic [1:0] FIN_WEIGHT = 2'd1;
  localparam logic [1:0] FIN_HOLD   = 2'd2;
  localparam logic [1:0] FIN_TIME   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TEMP_GUIDED = 3'd0;
  localparam logic [2:0] CFG_BREAD_THR   = 3'd1;
  localparam logic [2:0] CFG_BREAD_WAIT  = 3'd2;
  localparam logic [2:0] CFG_MAX_TOAST   = 3'd3;
  localparam logic [2:0] CFG_HOLD        = 3'd4;
  localparam logic [2:0] CFG_TEMP_TARGET = 3'd5;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 20;
  localparam int OUT_BITS      = 48;

  localparam logic [10:0] PROG_FULL  = 11'd1024;
  localparam logic [15:0] LOSS_TEN   = 16'd6554;
  localparam logic [11:0] LOSS_DEN   = 12'd2400;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/tws_div.sv
// Radix-2 restoring divider that retires one quotient bit per cycle.
module tws_div #(
  parameter int NW = 30,
  parameter int DW = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NW-1:0]         num,
  input  logic [DW-1:0]         den,
  output logic [NW-1:0]         quo,
  output tws_pkg::div_stat_t    stat
);
  import tws_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          fits;

  // One bit of the dividend shifts into the partial remainder each cycle.
  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      if (start) begin
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
        cnt       <= CW'(NW);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end else begin
          stat.done <= 1'b0;
        end
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (stat.busy) begin
      rem <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

### design/toast_weight_loss_sequencer_core.sv
// Top level of the toast weight-loss sequencer: phase control and datapath.
// Each sample request is taken in, processed by a short sequencer and answered
// with one result request. Most samples are taken in, updated and then loaded
// into the result register. A start sample runs the loss mapping through the
// bit-serial divider, then a multiply and a rounding step for the extra loss figure.
// The step into toasting adds a multiply, a rounding step and the target
// subtraction. A toasting sample may run two divisions, for the weight and the
// hold progress, one quotient bit per cycle. A stalled result request holds the
// sequencer before loading. A new sample is taken while the previous result
// still waits in the output register. Configuration writes must be made while no
// sample is in flight, which the block itself does not enforce; they apply from
// the next sample.
module toast_weight_loss_sequencer_core #(
  parameter int WEIGHT_BITS = 21,
  parameter int TIME_BITS   = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // now_ms[31:0], weight, temperature[13:0], start_req, button, zero fill
  input  logic [((WEIGHT_BITS+48+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // phase[2:0], progress[13:3], weight_added[35:14], show_frozen[36],
  // extra_loss[45:37], finish_cause[47:46]
  output logic [tws_pkg::OUT_BITS-1:0]           m_axis_tdata,
  input  logic                                   cfg_we,
  input  logic [tws_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [tws_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import tws_pkg::*;

  localparam int W  = WEIGHT_BITS;
  localparam int TB = TIME_BITS;
  localparam int DW = (W > 20) ? W : 20;
  localparam int NW = DW + 10;

  // Sequencer states.
  localparam logic [3:0] ST_IN        = 4'd0;
  localparam logic [3:0] ST_EXEC      = 4'd1;
  localparam logic [3:0] ST_LOSS_DIV  = 4'd2;
  localparam logic [3:0] ST_EXTRA_MUL = 4'd3;
  localparam logic [3:0] ST_EXTRA     = 4'd4;
  localparam logic [3:0] ST_RL_MUL    = 4'd5;
  localparam logic [3:0] ST_RL        = 4'd6;
  localparam logic [3:0] ST_TGT       = 4'd7;
  localparam logic [3:0] ST_WP        = 4'd8;
  localparam logic [3:0] ST_WP_DIV    = 4'd9;
  localparam logic [3:0] ST_TP        = 4'd10;
  localparam logic [3:0] ST_TP_DIV    = 4'd11;
  localparam logic [3:0] ST_FINISH    = 4'd12;
  localparam logic [3:0] ST_OUT       = 4'd13;

  // Configuration registers.
  logic        temp_guided;
  logic [9:0]  bread_threshold;
  logic [15:0] bread_wait_ms;
  logic [19:0] max_toast_ms;
  logic [19:0] hold_ms;
  logic [12:0] temp_target;

  // Captured sample.
  logic [TB-1:0]       now_r;
  logic signed [W-1:0] w_r;
  logic signed [13:0]  t_r;
  logic                start_r;
  logic                btn_r;

  // Run state.
  logic [3:0]          state;
  logic [2:0]          cur_phase;
  logic signed [W-1:0] baseline_weight;
  logic signed [W-1:0] start_weight;
  logic signed [W-1:0] prev_weight;
  logic [15:0]         loss_fraction;
  logic signed [W:0]   target_weight;
  logic signed [W-1:0] required_loss;
  logic [TB-1:0]       phase_start_ms;
  logic [TB-1:0]       toast_start_ms;
  logic                temp_is_stable;
  logic [TB-1:0]       stable_since_ms;
  logic signed [13:0]  prev_temperature;
  logic [1:0]          finish_reg;
  logic [8:0]          extra_r;
  logic [25:0]         ex_prod;
  logic signed [W+16:0] rl_prod;
  logic [10:0]         wp;
  logic [10:0]         tp;
  logic                hold_done;
  logic [10:0]         prog_r;

  // Divider hookup.
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic [NW-1:0] div_quo;
  div_stat_t     div_stat;

  tws_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Sample field compare logic.
  logic signed [W:0]  d_base, d_prev, num_w;
  logic [W:0]         a_base, a_prev;
  logic [TB-1:0]      td_phase, td_toast, since;
  logic signed [14:0] d_temp;
  logic               temp_ok;
  logic [8:0]         t_clamp;
  logic [9:0]         loss_diff;
  logic [25:0]        loss_num;
  logic signed [33:0] wa_ext;
  logic [21:0]        wa_sat;
  logic [26:0]        ex_round;
  logic [10:0]        ex_raw;
  logic [10:0]        prog_sel;
  logic               weight_done, time_done;

  assign d_base   = (W+1)'(w_r) - (W+1)'(baseline_weight);
  assign d_prev   = (W+1)'(w_r) - (W+1)'(prev_weight);
  assign num_w    = (W+1)'(start_weight) - (W+1)'(w_r);
  assign a_base   = d_base[W] ? (W+1)'(-d_base) : d_base;
  assign a_prev   = d_prev[W] ? (W+1)'(-d_prev) : d_prev;
  assign td_phase = now_r - phase_start_ms;
  assign td_toast = now_r - toast_start_ms;
  assign since    = now_r - stable_since_ms;
  assign d_temp   = 15'(t_r) - 15'(prev_temperature);
  assign temp_ok  = (t_r >= $signed({1'b0, temp_target})) && (d_temp > -15'sd8) &&
                    (d_temp < 15'sd8);

  // Start temperature clamped to 12.5..20 degrees, then mapped to Q16 loss.
  always_comb begin
    if (t_r < 14'sd200) begin
      t_clamp = 9'd200;
    end else if (t_r > 14'sd320) begin
      t_clamp = 9'd320;
    end else begin
      t_clamp = t_r[8:0];
    end
  end
  assign loss_diff = 10'd560 - {1'b0, t_clamp};
  assign loss_num  = {loss_diff, 16'h0000} + 26'd1200;

  // Weight added during calibration, saturated to the field width.
  assign wa_ext = 34'(d_base);
  always_comb begin
    if (wa_ext > 34'sd2097151) begin
      wa_sat = 22'h1FFFFF;
    end else if (wa_ext < -34'sd2097152) begin
      wa_sat = 22'h200000;
    end else begin
      wa_sat = wa_ext[21:0];
    end
  end

  assign ex_round = {1'b0, ex_prod} + 27'd32768;
  assign ex_raw   = ex_round[26:16];

  assign prog_sel    = (temp_guided && tp > wp) ? tp : wp;
  assign weight_done = $signed({w_r[W-1], w_r}) <= target_weight;
  assign time_done   = td_toast >= TB'(max_toast_ms);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_guided     <= 1'b0;
      bread_threshold <= 10'd80;
      bread_wait_ms   <= 16'd15000;
      max_toast_ms    <= 20'd300000;
      hold_ms         <= 20'd150000;
      temp_target     <= 13'd1920;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TEMP_GUIDED: temp_guided     <= cfg_data[0];
        CFG_BREAD_THR:   bread_threshold <= cfg_data[9:0];
        CFG_BREAD_WAIT:  bread_wait_ms   <= cfg_data[15:0];
        CFG_MAX_TOAST:   max_toast_ms    <= cfg_data;
        CFG_HOLD:        hold_ms         <= cfg_data;
        CFG_TEMP_TARGET: temp_target     <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Divider request selection.
  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(loss_num);
    div_den   = DW'(LOSS_DEN);
    if (state == ST_EXEC && cur_phase == PH_IDLE && start_r) begin
      div_start = 1'b1;
    end else if (state == ST_WP) begin
      div_num   = NW'({num_w[W-1:0], 10'b0});
      div_den   = DW'(required_loss);
      div_start = (required_loss > 0) && (num_w > 0) &&
                  (num_w < (W+1)'(required_loss));
    end else if (state == ST_TP) begin
      div_num   = NW'({since[19:0], 10'b0});
      div_den   = DW'(hold_ms);
      div_start = temp_guided && temp_is_stable && (since < TB'(hold_ms));
    end
  end

  assign s_axis_tready = (state == ST_IN);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IN;
      cur_phase        <= PH_IDLE;
      m_axis_tvalid    <= 1'b0;
      baseline_weight  <= '0;
      start_weight     <= '0;
      prev_weight      <= '0;
      loss_fraction    <= '0;
      target_weight    <= '0;
      required_loss    <= '0;
      phase_start_ms   <= '0;
      toast_start_ms   <= '0;
      temp_is_stable   <= 1'b0;
      stable_since_ms  <= '0;
      prev_temperature <= '0;
      finish_reg       <= FIN_NONE;
      extra_r          <= '0;
      prog_r           <= '0;
    end else begin
      // The output state reloads the register itself when it is taken.
      if (m_axis_tvalid && m_axis_tready && (state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IN: begin
          if (s_axis_tvalid) begin
            now_r   <= s_axis_tdata[TB-1:0];
            w_r     <= s_axis_tdata[32+W-1:32];
            t_r     <= s_axis_tdata[W+45:W+32];
            start_r <= s_axis_tdata[W+46];
            btn_r   <= s_axis_tdata[W+47];
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          prog_r <= '0;
          case (cur_phase)
            PH_IDLE: begin
              if (start_r) begin
                baseline_weight <= w_r;
                start_weight    <= w_r;
                phase_start_ms  <= now_r;
                cur_phase       <= PH_WAIT;
                state           <= ST_LOSS_DIV;
              end else begin
                state <= ST_OUT;
              end
            end
            PH_WAIT: begin
              if ((a_base > (W+1)'(bread_threshold)) || (td_phase > TB'(bread_wait_ms))) begin
                start_weight   <= w_r;
                prev_weight    <= w_r;
                phase_start_ms <= now_r;
                cur_phase      <= PH_CAL;
              end
              state <= ST_OUT;
            end
            PH_CAL: begin
              if (a_prev < (W+1)'(8)) begin
                if (td_phase > TB'(1000)) begin
                  start_weight     <= w_r;
                  toast_start_ms   <= now_r;
                  temp_is_stable   <= 1'b0;
                  stable_since_ms  <= '0;
                  prev_temperature <= '0;
                  cur_phase        <= PH_TOAST;
                  state            <= ST_RL_MUL;
                end else begin
                  state <= ST_OUT;
                end
              end else begin
                phase_start_ms <= now_r;
                state          <= ST_OUT;
              end
              prev_weight <= w_r;
            end
            PH_TOAST: begin
              // Temperature stability tracking.
              if (temp_guided) begin
                if (temp_ok) begin
                  if (!temp_is_stable) begin
                    temp_is_stable  <= 1'b1;
                    stable_since_ms <= now_r;
                  end
                end else begin
                  temp_is_stable  <= 1'b0;
                  stable_since_ms <= '0;
                end
                prev_temperature <= t_r;
              end
              state <= ST_WP;
            end
            PH_READY: begin
              if (btn_r) begin
                cur_phase <= PH_IDLE;
              end
              state <= ST_OUT;
            end
            default: begin
              cur_phase <= PH_IDLE;
              state     <= ST_OUT;
            end
          endcase
        end
        ST_LOSS_DIV: begin
          if (div_stat.done) begin
            loss_fraction <= div_quo[15:0];
            state         <= ST_EXTRA_MUL;
          end
        end
        ST_EXTRA_MUL: begin
          ex_prod <= (loss_fraction > LOSS_TEN) ?
                     26'(12'(loss_fraction - LOSS_TEN) * 14'd10000) : '0;
          state   <= ST_EXTRA;
        end
        ST_EXTRA: begin
          extra_r <= (ex_raw > 11'd500) ? 9'd500 : ex_raw[8:0];
          state   <= ST_OUT;
        end
        ST_RL_MUL: begin
          rl_prod <= (W+17)'(start_weight * $signed({1'b0, loss_fraction})) +
                     (W+17)'(32768);
          state   <= ST_RL;
        end
        ST_RL: begin
          required_loss <= rl_prod[W+15:16];
          state         <= ST_TGT;
        end
        ST_TGT: begin
          target_weight <= (W+1)'(start_weight) - (W+1)'(required_loss);
          state         <= ST_OUT;
        end
        ST_WP: begin
          // Weight progress; the divider runs only for a partial loss.
          if (div_start) begin
            state <= ST_WP_DIV;
          end else begin
            wp    <= ((required_loss > 0) && (num_w > 0)) ? PROG_FULL : '0;
            state <= ST_TP;
          end
        end
        ST_WP_DIV: begin
          if (div_stat.done) begin
            wp    <= div_quo[10:0];
            state <= ST_TP;
          end
        end
        ST_TP: begin
          // Hold progress while the temperature is stable.
          if (div_start) begin
            hold_done <= 1'b0;
            tp        <= '0;
            state     <= ST_TP_DIV;
          end else begin
            if (temp_guided && temp_is_stable) begin
              tp        <= PROG_FULL;
              hold_done <= 1'b1;
            end else begin
              tp        <= '0;
              hold_done <= 1'b0;
            end
            state <= ST_FINISH;
          end
        end
        ST_TP_DIV: begin
          if (div_stat.done) begin
            tp    <= div_quo[10:0];
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          prog_r <= prog_sel;
          if (weight_done || hold_done || time_done) begin
            finish_reg <= weight_done ? FIN_WEIGHT : (hold_done ? FIN_HOLD : FIN_TIME);
            cur_phase  <= PH_READY;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Load the result once the output register is free.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid       <= 1'b1;
            m_axis_tdata[2:0]   <= cur_phase;
            m_axis_tdata[13:3]  <= (cur_phase == PH_READY) ? PROG_FULL :
                                   ((cur_phase == PH_TOAST) ? prog_r : '0);
            m_axis_tdata[35:14] <= (cur_phase == PH_CAL) ? wa_sat : '0;
            m_axis_tdata[36]    <= (cur_phase != PH_IDLE) && (loss_fraction > LOSS_TEN);
            m_axis_tdata[45:37] <= (cur_phase != PH_IDLE) ? extra_r : '0;
            m_axis_tdata[47:46] <= (cur_phase == PH_READY) ? finish_reg : FIN_NONE;
            state               <= ST_IN;
          end
        end
        default: state <= ST_IN;
      endcase
    end
  end

endmodule

### design/tws_check.sv
// Port-level checks of the sequencer result stream, bound to the top level.
module tws_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic [tws_pkg::OUT_BITS-1:0]   m_axis_tdata
);
  import tws_pkg::*;

  logic [2:0]  phase;
  logic [10:0] progress;
  logic [1:0]  cause;

  assign phase    = m_axis_tdata[2:0];
  assign progress = m_axis_tdata[13:3];
  assign cause    = m_axis_tdata[47:46];

  // No result request is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A finish cause is reported only in the ready phase.
  a_cause_ready: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && cause != FIN_NONE) |-> phase == PH_READY)
    else $error("finish cause outside ready phase");

  // The ready phase always shows full progress and a cause.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && phase == PH_READY) |-> (progress == PROG_FULL && cause != FIN_NONE))
    else $error("ready phase without full progress or cause");

  // Before toasting the progress stays at zero.
  a_early_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (phase == PH_IDLE || phase == PH_WAIT || phase == PH_CAL))
    |-> progress == '0)
    else $error("progress before toasting");

endmodule

bind toast_weight_loss_sequencer_core tws_check u_tws_check (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb.sv
// Testbench for the toast weight-loss sequencer: random and directed sample streams.
`timescale 1ns / 100ps

// Holds the expected phase and display values and checks each result against them.
class toast_scoreboard;
  bit        temp_guided;
  bit [9:0]  bread_thr;
  bit [15:0] bread_wait;
  bit [19:0] max_toast;
  bit [19:0] hold_time;
  bit [12:0] temp_target;

  logic [2:0] phase;
  longint     base_w;
  longint     start_w;
  longint     prev_w;
  longint     target_w;
  longint     req_loss;
  longint     loss_frac;
  bit [31:0]  phase_ms;
  bit [31:0]  toast_ms;
  bit [31:0]  stable_ms;
  bit         stable;
  longint     prev_t;
  logic [1:0] cause;

  logic [47:0] pending_q[$];
  int          errors;

  function new();
    temp_guided = 0; bread_thr = 80; bread_wait = 15000;
    max_toast = 300000; hold_time = 150000; temp_target = 1920;
    phase = tws_pkg::PH_IDLE;
    base_w = 0; start_w = 0; prev_w = 0; target_w = 0; req_loss = 0; loss_frac = 0;
    phase_ms = 0; toast_ms = 0; stable_ms = 0; stable = 0; prev_t = 0;
    cause = tws_pkg::FIN_NONE;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [19:0] val);
    case (idx)
      tws_pkg::CFG_TEMP_GUIDED: temp_guided = val[0];
      tws_pkg::CFG_BREAD_THR:   bread_thr = val[9:0];
      tws_pkg::CFG_BREAD_WAIT:  bread_wait = val[15:0];
      tws_pkg::CFG_MAX_TOAST:   max_toast = val;
      tws_pkg::CFG_HOLD:        hold_time = val;
      tws_pkg::CFG_TEMP_TARGET: temp_target = val[12:0];
      default: ;
    endcase
  endfunction

  // Advances the phase for one accepted sample and queues the result it yields.
  function void note_sample(bit [31:0] now, longint w, longint t, bit start, bit btn);
    longint     tc;
    longint     num;
    longint     wp;
    longint     tp;
    longint     prog;
    longint     added;
    longint     extra;
    bit [31:0]  since;
    bit [31:0]  elapsed;
    bit         w_done;
    bit         h_done;
    bit         t_done;
    logic [1:0] fin_out;
    prog = 0; added = 0; extra = 0;
    case (phase)
      tws_pkg::PH_IDLE: begin
        if (start) begin
          tc = (t < 200) ? 200 : ((t > 320) ? 320 : t);
          loss_frac = ((560 - tc) * 65536 + 1200) / 2400;
          base_w = w; start_w = w; phase_ms = now;
          phase = tws_pkg::PH_WAIT;
        end
      end
      tws_pkg::PH_WAIT: begin
        elapsed = now - phase_ms;
        if ((w - base_w > longint'(bread_thr)) || (base_w - w > longint'(bread_thr)) ||
            elapsed > bread_wait) begin
          start_w = w; prev_w = w; phase_ms = now;
          phase = tws_pkg::PH_CAL;
        end
      end
      tws_pkg::PH_CAL: begin
        elapsed = now - phase_ms;
        if (w - prev_w < 8 && prev_w - w < 8) begin
          if (elapsed > 1000) begin
            start_w = w;
            req_loss = (start_w * loss_frac + 32768) >>> 16;
            target_w = start_w - req_loss;
            toast_ms = now; stable = 0; stable_ms = 0; prev_t = 0;
            phase = tws_pkg::PH_TOAST;
          end
        end else begin
          phase_ms = now;
        end
        prev_w = w;
      end
      tws_pkg::PH_TOAST: begin
        wp = 0; tp = 0; h_done = 0;
        if (temp_guided) begin
          if (t >= longint'(temp_target) && t - prev_t < 8 && prev_t - t < 8) begin
            if (!stable) begin
              stable = 1; stable_ms = now;
            end
          end else begin
            stable = 0; stable_ms = 0;
          end
          prev_t = t;
        end
        num = start_w - w;
        if (req_loss > 0 && num > 0) wp = (num >= req_loss) ? 1024 : (num * 1024) / req_loss;
        if (temp_guided && stable) begin
          since = now - stable_ms;
          if (since >= hold_time) begin
            tp = 1024; h_done = 1;
          end else begin
            tp = (longint'(since) * 1024) / hold_time;
          end
        end
        prog = (temp_guided && tp > wp) ? tp : wp;
        w_done = (w <= target_w);
        elapsed = now - toast_ms;
        t_done = (elapsed >= max_toast);
        if (w_done || h_done || t_done) begin
          cause = w_done ? tws_pkg::FIN_WEIGHT : (h_done ? tws_pkg::FIN_HOLD : tws_pkg::FIN_TIME);
          phase = tws_pkg::PH_READY;
        end
      end
      tws_pkg::PH_READY: begin
        if (btn) phase = tws_pkg::PH_IDLE;
      end
      default: phase = tws_pkg::PH_IDLE;
    endcase

    if (phase == tws_pkg::PH_CAL) begin
      added = w - base_w;
      if (added > 2097151) added = 2097151;
      if (added < -2097152) added = -2097152;
    end
    if (phase == tws_pkg::PH_READY) prog = 1024;
    if (phase != tws_pkg::PH_TOAST && phase != tws_pkg::PH_READY) prog = 0;
    if (phase != tws_pkg::PH_IDLE && loss_frac > 6554) begin
      extra = ((loss_frac - 6554) * 10000 + 32768) / 65536;
      if (extra > 500) extra = 500;
    end
    fin_out = (phase == tws_pkg::PH_READY) ? cause : tws_pkg::FIN_NONE;
    pending_q.push_back({fin_out, extra[8:0],
                         (phase != tws_pkg::PH_IDLE && loss_frac > 6554) ? 1'b1 : 1'b0,
                         added[21:0], prog[10:0], phase});
  endfunction

  function void report(string field, longint exp_v, longint act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    errors++;
  endfunction

  // Compares one result with the oldest expectation, field by field.
  function void check_result(logic [47:0] act);
    logic [47:0] exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, act);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (act[2:0] !== exp_r[2:0]) report("phase", exp_r[2:0], act[2:0]);
    if (act[13:3] !== exp_r[13:3]) report("progress", exp_r[13:3], act[13:3]);
    if (act[35:14] !== exp_r[35:14])
      report("weight_added", $signed(exp_r[35:14]), $signed(act[35:14]));
    if (act[36] !== exp_r[36]) report("show_frozen", exp_r[36], act[36]);
    if (act[45:37] !== exp_r[45:37]) report("extra_loss", exp_r[45:37], act[45:37]);
    if (act[47:46] !== exp_r[47:46]) report("finish_cause", exp_r[47:46], act[47:46]);
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 50000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [19:0] cfg_data;

  toast_scoreboard sb;
  bit        quiet;
  bit [31:0] now_ms;
  longint    last_w;
  int        idle_cycles = 0;

  toast_weight_loss_sequencer_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Result side: random stalls, result checks and the no-progress watchdog.
  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 8);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (rst || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one sample request and notes it once the block takes it.
  task automatic send_sample(bit [31:0] now, longint w, longint t, bit start, bit btn);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b0, btn, start, t[13:0], w[20:0], now};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(now, w, t, start, btn);
    last_w = w;
  endtask

  // Drains all pending results, then lets the block settle before a register write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_settings(bit tg, int thr, int bwait, int maxt, int hold, int ttarget);
    int vals[6];
    vals = '{tg, thr, bwait, maxt, hold, ttarget};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_data <= 20'(vals[i]);
      @(posedge clk);
      sb.set_reg(3'(i), 20'(vals[i]));
    end
    cfg_we <= 1'b0;
  endtask

  // Builds one sample shaped by the phase the block is expected to be in.
  task automatic random_sample();
    int     r;
    longint w;
    longint t;
    bit     start;
    bit     btn;
    r = $urandom_range(0, 99);
    now_ms += (r < 2) ? $urandom : ((r < 4) ? $urandom_range(0, 70000) : $urandom_range(50, 100));
    w = last_w;
    t = $urandom_range(150, 370);
    start = $urandom_range(0, 1);
    btn = $urandom_range(0, 1);
    case (sb.phase)
      tws_pkg::PH_IDLE: begin
        start = ($urandom_range(0, 2) == 0);
        w = ($urandom_range(0, 7) == 0) ? longint'($signed(21'($urandom)))
                                        : $urandom_range(0, 16000);
        if ($urandom_range(0, 5) == 0) t = longint'($urandom_range(0, 9215)) - 1024;
      end
      tws_pkg::PH_WAIT:
        w = sb.base_w + (($urandom_range(0, 5) == 0) ? longint'($urandom_range(0, 2500)) - 1250
                                                     : longint'($urandom_range(0, 20)) - 10);
      tws_pkg::PH_CAL:
        w = sb.prev_w + (($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 400)) - 200
                                                     : longint'($urandom_range(0, 14)) - 7);
      tws_pkg::PH_TOAST: begin
        w = last_w - (($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 20)) - 30
                                                  : longint'($urandom_range(0, 60)));
        t = ($urandom_range(0, 4) == 0) ? longint'($urandom_range(0, 9215)) - 1024
                                        : longint'(sb.temp_target) + $urandom_range(0, 5);
      end
      default: btn = ($urandom_range(0, 2) == 0);
    endcase
    // Occasional pure noise keeps every field bit moving.
    if ($urandom_range(0, 19) == 0) begin
      w = longint'($signed(21'($urandom)));
      t = longint'($urandom_range(0, 9215)) - 1024;
    end
    if (w > 1048575) w = 1048575;
    if (w < -1048576) w = -1048576;
    if (t > 8191) t = 8191;
    send_sample(now_ms, w, t, start, btn);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    quiet = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    now_ms = 1000;
    last_w = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed run: field extremes, clamped start temperatures, bread jump and timeout,
    // calibration restarts, weight finish and the button in and out of ready.
    write_settings(1, 80, 1000, 6000, 2000, 1920);
    send_sample(1000, 1048575, 8191, 0, 1);
    send_sample(1100, -1048576, -1024, 0, 0);
    send_sample(1200, 8000, -1024, 1, 0);
    send_sample(1300, 8010, 300, 0, 1);
    send_sample(1400, 10000, 300, 0, 0);
    send_sample(1500, 10003, 300, 0, 0);
    send_sample(2100, 10005, 300, 0, 0);
    send_sample(2700, 10004, 300, 1, 0);
    send_sample(2800, 9800, 2000, 0, 0);
    send_sample(2900, 9000, 2003, 0, 0);
    send_sample(3000, 8400, 2004, 0, 0);
    send_sample(3100, 8400, 2004, 1, 0);
    send_sample(3200, 8400, 2004, 0, 1);
    send_sample(3300, -500, 8191, 1, 0);
    send_sample(4800, -500, 8191, 0, 0);
    send_sample(4900, 1048575, 100, 0, 0);
    send_sample(5000, -1048576, 100, 0, 0);
    send_sample(5100, -1048570, 100, 0, 0);
    send_sample(6200, -1048572, 100, 0, 0);
    send_sample(6300, -1048572, 1920, 0, 0);
    send_sample(6400, -1048572, 1921, 0, 0);
    send_sample(12400, -1048572, 1921, 0, 0);
    send_sample(12500, -1048572, 1921, 0, 1);
    now_ms = 12500;

    // Random phases under low extremes, high extremes and random settings.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_settings(0, 0, 0, 0, 1, 0);
        1: write_settings(1, 1023, 65535, 1048575, 1048575, 8191);
        default: write_settings($urandom_range(0, 1), $urandom_range(0, 1023),
                                $urandom_range(0, 3000), $urandom_range(0, 20000),
                                $urandom_range(1, 5000), $urandom_range(0, 3000));
      endcase
      for (int i = 0; i < 290; i++) begin
        quiet = (p == 3);
        random_sample();
      end
    end
    quiet = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### files.f
design/tws_pkg.sv
design/tws_div.sv
design/toast_weight_loss_sequencer_core.sv
design/tws_check.sv
tb/sv/tb.sv
